// ===== rtl/sprb_pkg.sv =====
package sprb_pkg;

    localparam int DISP_COLS  = 480;
    localparam int DISP_LINES = 320;
    localparam int MAX_W      = 16;
    localparam int MAX_SCALE  = 4;

    localparam int COL_W  = 9;
    localparam int LINE_W = 10;
    localparam int ADDR_W = 18;

    typedef struct packed {
        logic [15:0] row_bits;
        logic [4:0]  sprite_width;
        logic [5:0]  row_index;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
        logic [2:0]  scale;
        logic [15:0] color;
        logic        active;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        logic [2:0]        run_len;
        logic [1:0]        wrap_len;
        logic [15:0]       pixel_color;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic prep;
        logic next_pixel;
        logic next_line;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic prep_empty;
        logic cur_set;
        logic pix_last;
        logic line_last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/sprb_ctrl.sv =====
module sprb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sprb_pkg::t_stat i_stat,
    output sprb_pkg::t_cmd  o_cmd
);
    import sprb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = i_stat.prep_empty ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (!i_stat.cur_set) begin
                    cmd.next_pixel = 1'b1;
                    if (i_stat.pix_last) begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (i_stat.line_last) begin
                        cmd.next_pixel = 1'b1;
                        if (i_stat.pix_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        cmd.next_line = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> i_stat.out_free)
        else $error("span issued while the output register is still occupied");

    a_final_span_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && i_stat.line_last && i_stat.pix_last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after the final span");

endmodule

// ===== rtl/sprb_dp.sv =====
module sprb_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sprb_pkg::t_in_word  i_in_word,
    input  sprb_pkg::t_cmd      i_cmd,
    output sprb_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sprb_pkg::t_out_word o_out_word
);
    import sprb_pkg::*;

    logic [15:0]       r_pix;
    logic [COL_W-1:0]  r_col;
    logic [2:0]        r_s;
    logic [1:0]        r_k;
    logic [2:0]        r_vl;
    logic [LINE_W-1:0] r_base;
    logic [ADDR_W-1:0] r_base_addr;
    logic [ADDR_W-1:0] r_line_addr;
    logic [15:0]       r_color;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [4:0]        ld_w;
    logic [2:0]        ld_s;
    logic [15:0]       ld_mask;
    logic [15:0]       ld_bits;
    logic [15:0]       ld_pix;
    logic [COL_W-1:0]  ld_col;
    logic [LINE_W-1:0] ld_base;
    logic [LINE_W-1:0] pr_room;
    logic [2:0]        pr_vl;
    logic [COL_W:0]    col_sum;
    logic [COL_W-1:0]  col_next;
    logic [COL_W-1:0]  col_room;
    logic [2:0]        run;
    logic [1:0]        wrap;

    always_comb begin
        ld_w    = (i_in_word.sprite_width > 5'(MAX_W)) ? 5'(MAX_W) : i_in_word.sprite_width;
        ld_s    = (i_in_word.scale > 3'(MAX_SCALE)) ? 3'(MAX_SCALE) : i_in_word.scale;
        ld_mask = 16'((17'd1 << ld_w) - 17'd1);
        ld_bits = i_in_word.row_bits & ld_mask;
        ld_pix  = ld_bits << (5'(MAX_W) - ld_w);
        if (!i_in_word.active || ld_s == 3'd0) begin
            ld_pix = '0;
        end
        ld_col  = (i_in_word.pos_x >= 9'(DISP_COLS)) ? i_in_word.pos_x - 9'(DISP_COLS)
                                                     : i_in_word.pos_x;
        ld_base = LINE_W'(i_in_word.pos_y) + LINE_W'(i_in_word.row_index) * LINE_W'(ld_s);

        pr_room = LINE_W'(DISP_LINES) - r_base;
        if (r_base >= LINE_W'(DISP_LINES)) begin
            pr_vl = 3'd0;
        end else if (pr_room > LINE_W'(r_s)) begin
            pr_vl = r_s;
        end else begin
            pr_vl = pr_room[2:0];
        end

        col_sum  = {1'b0, r_col} + (COL_W + 1)'(r_s);
        col_next = (col_sum >= (COL_W + 1)'(DISP_COLS))
                 ? COL_W'(col_sum - (COL_W + 1)'(DISP_COLS)) : col_sum[COL_W-1:0];
        col_room = COL_W'(DISP_COLS) - r_col;
        run      = (COL_W'(r_s) < col_room) ? r_s : col_room[2:0];
        wrap     = 2'(r_s - run);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix   <= ld_pix;
            r_col   <= ld_col;
            r_s     <= ld_s;
            r_k     <= 2'd0;
            r_base  <= ld_base;
            r_color <= i_in_word.color;
        end
        if (i_cmd.prep) begin
            r_vl        <= pr_vl;
            r_base_addr <= ADDR_W'(r_base) * ADDR_W'(DISP_COLS);
            r_line_addr <= ADDR_W'(r_base) * ADDR_W'(DISP_COLS);
        end
        if (i_cmd.emit) begin
            r_out_word.frame_address <= r_line_addr + ADDR_W'(r_col);
            r_out_word.run_len       <= run;
            r_out_word.wrap_len      <= wrap;
            r_out_word.pixel_color   <= r_color;
            r_out_word.last          <= o_stat.line_last && o_stat.pix_last;
        end
        if (i_cmd.next_pixel) begin
            r_pix       <= {r_pix[14:0], 1'b0};
            r_col       <= col_next;
            r_k         <= 2'd0;
            r_line_addr <= r_base_addr;
        end else if (i_cmd.next_line) begin
            r_k         <= r_k + 2'd1;
            r_line_addr <= r_line_addr + ADDR_W'(DISP_COLS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.prep_empty = (r_pix == 16'd0) || (pr_vl == 3'd0);
    assign o_stat.cur_set    = r_pix[15];
    assign o_stat.pix_last   = (r_pix[14:0] == 15'd0);
    assign o_stat.line_last  = ({1'b0, r_k} == (r_vl - 3'd1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_addr_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_word.frame_address < ADDR_W'(DISP_COLS * DISP_LINES)))
        else $error("span address lies outside the frame buffer");

    a_span_covers_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> ((r_out_word.run_len + 3'(r_out_word.wrap_len)) == $past(r_s)))
        else $error("run and wrap lengths do not add up to the scale");

endmodule

// ===== rtl/scaled_sprite_row_blitter.sv =====
// Channel   Direction  Valid        Ready        Word
// input     in         i_in_valid   o_in_ready   i_in_word  (t_in_word)
// output    out        o_out_valid  i_out_ready  o_out_word (t_out_word)
//
// A row is loaded and then prepared; the controller then steps the datapath through each pixel up
// to the last set one, one span at a time, emitting one span for each visible line of a set pixel.
// A row with nothing to draw goes from preparing straight back to idle.
// A stalled output holds the stepping; a new row is taken while the last span still waits.
// Reset is synchronous and active low and clears only the controller and the output valid.
module scaled_sprite_row_blitter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sprb_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sprb_pkg::t_out_word o_out_word
);
    import sprb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sprb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sprb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
